[sv/gda_pkg.sv]
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, codes and calendar helpers for the Gregorian date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

    localparam int YEAR_W  = 15;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int MODE_W  = 3;
    localparam int AMT_W   = 15;
    localparam int CNT_W   = 18;   // amount * 7 in week mode
    localparam int REM_W   = 9;    // year mod 400
    localparam int QUO_W   = 7;    // year / 400
    localparam int DIV_W   = YEAR_W - 4;   // year / 16
    localparam int RECIP_W = 11;
    localparam int RECIP_SH = 15;
    localparam int UNIT_W  = 10;   // up to 1000 years per unit
    localparam int PROD_W  = AMT_W + UNIT_W;

    localparam logic [YEAR_W-1:0]  YEAR_MAX = 15'd32767;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [REM_W-1:0]   REM_LAST   = 9'd399;
    // x * 1311 >> 15 == x / 25 for x < 2048
    localparam logic [RECIP_W-1:0] RECIP_25   = 11'd1311;

    localparam logic [MODE_W-1:0] MODE_DAY        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WEEK       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MONTH      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_YEAR       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DECADE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CENTURY    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_MILLENNIUM = 3'd6;
    localparam logic [MODE_W-1:0] MODE_NONE       = 3'd7;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [MODE_W-1:0]  mode;
        logic [AMT_W-1:0]   amount;
    } item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic               year_overflow;
        logic               bad_date;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rem_step;
        logic check;
        logic day_step;
        logic mon_step;
        logic mul;
        logic add;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic              cnt_zero;
        logic              bad_now;
        logic [MODE_W-1:0] mode;
        logic              out_free;
    } sts_t;

    // leap test from year mod 400
    function automatic logic is_leap(input logic [REM_W-1:0] rem);
        logic res;
        res = (rem[1:0] == 2'b00) && (rem != 9'd100) && (rem != 9'd200)
              && (rem != 9'd300);
        return res;
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:               len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [UNIT_W-1:0] mode_unit(input logic [MODE_W-1:0] mode);
        logic [UNIT_W-1:0] u;
        unique case (mode)
            MODE_DECADE:     u = 10'd10;
            MODE_CENTURY:    u = 10'd100;
            MODE_MILLENNIUM: u = 10'd1000;
            default:         u = 10'd1;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[sv/gda_dp.sv]
// ----------------------------------------------------------------------------
// gda_dp
// Datapath: date registers, year mod 400 remainder, step counter, year
// multiply/add and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_dp
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gda_pkg::item_t   item,
    input  wire gda_pkg::cmd_t    cmd,
    output gda_pkg::sts_t         sts,
    input  wire logic             result_stall,
    output logic                  result_valid,
    output gda_pkg::result_t      result
);
    import gda_pkg::*;

    logic [YEAR_W-1:0]  y_reg,    y_next;
    logic [MONTH_W-1:0] m_reg,    m_next;
    logic [DAY_W-1:0]   d_reg,    d_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [AMT_W-1:0]   amt_reg,  amt_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [REM_W-1:0]   rem_reg,  rem_next;
    logic [QUO_W-1:0]   q_reg,    q_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               ovf_reg,  ovf_next;
    logic               bad_reg,  bad_next;
    logic               valid_reg, valid_next;
    result_t            out_reg,  out_next;

    logic               leap;
    logic [DAY_W-1:0]   dim;
    logic [MONTH_W-1:0] nm;
    logic [DAY_W-1:0]   nlen;
    logic [DIV_W+RECIP_W-1:0] recip_prod;
    logic [YEAR_W-1:0]  q_by_400;
    logic [YEAR_W-1:0]  y_less;
    logic [REM_W-1:0]   rem_inc;
    logic [YEAR_W:0]    y_inc;
    logic [PROD_W:0]    sum;
    logic               at_top;

    assign leap      = is_leap(rem_reg);
    assign dim       = days_in(m_reg, leap);
    assign nm        = (m_reg == MONTH_DEC) ? MONTH_JAN : m_reg + 4'd1;
    assign nlen      = days_in(nm, leap);
    // year / 400 = (year / 16) / 25
    assign recip_prod = item.start_year[YEAR_W-1:4] * RECIP_25;
    // 400 = 256 + 128 + 16
    assign q_by_400  = {q_reg, 8'd0} + {1'b0, q_reg, 7'd0} + {4'd0, q_reg, 4'd0};
    assign y_less    = y_reg - q_by_400;
    assign rem_inc   = (rem_reg == REM_LAST) ? '0 : rem_reg + 9'd1;
    assign y_inc     = {1'b0, y_reg} + 16'd1;
    assign sum       = {{(PROD_W + 1 - YEAR_W){1'b0}}, y_reg} + {1'b0, prod_reg};
    assign at_top    = (y_reg == YEAR_MAX);

    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.bad_now  = (m_reg == 4'd0) || (m_reg > MONTH_DEC) || (d_reg == 5'd0)
                          || (d_reg > dim);
    assign sts.mode     = mode_reg;
    assign sts.out_free = !valid_reg || !result_stall;

    always_comb
    begin
        y_next     = y_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        mode_next  = mode_reg;
        amt_next   = amt_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        prod_next  = prod_reg;
        ovf_next   = ovf_reg;
        bad_next   = bad_reg;
        valid_next = valid_reg;
        out_next   = out_reg;

        if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            y_next    = item.start_year;
            m_next    = item.start_month;
            d_next    = item.start_day;
            mode_next = item.mode;
            amt_next  = item.amount;
            rem_next  = '0;
            q_next    = recip_prod[RECIP_SH +: QUO_W];
            ovf_next  = 1'b0;
            bad_next  = 1'b0;
        end

        if (cmd.rem_step)
        begin
            rem_next = y_less[REM_W-1:0];
        end

        if (cmd.check)
        begin
            bad_next = sts.bad_now;
            if (mode_reg == MODE_WEEK)
                cnt_next = ({3'b0, amt_reg} << 3) - {3'b0, amt_reg};
            else
                cnt_next = {3'b0, amt_reg};
        end

        if (cmd.day_step)
        begin
            if (d_reg == dim)
            begin
                if (m_reg == MONTH_DEC)
                begin
                    if (at_top)
                    begin
                        ovf_next = 1'b1;
                        cnt_next = '0;
                    end
                    else
                    begin
                        d_next   = 5'd1;
                        m_next   = MONTH_JAN;
                        y_next   = y_inc[YEAR_W-1:0];
                        rem_next = rem_inc;
                        cnt_next = cnt_reg - 18'd1;
                    end
                end
                else
                begin
                    d_next   = 5'd1;
                    m_next   = nm;
                    cnt_next = cnt_reg - 18'd1;
                end
            end
            else
            begin
                d_next   = d_reg + 5'd1;
                cnt_next = cnt_reg - 18'd1;
            end
        end

        if (cmd.mon_step)
        begin
            if ((m_reg == MONTH_DEC) && at_top)
            begin
                ovf_next = 1'b1;
                cnt_next = '0;
            end
            else
            begin
                m_next   = nm;
                cnt_next = cnt_reg - 18'd1;
                // leap flag only matters when landing on February, same year
                if (d_reg > nlen)
                    d_next = nlen;
                if (m_reg == MONTH_DEC)
                begin
                    y_next   = y_inc[YEAR_W-1:0];
                    rem_next = rem_inc;
                end
            end
        end

        if (cmd.mul)
        begin
            prod_next = amt_reg * mode_unit(mode_reg);
        end

        if (cmd.add)
        begin
            if (sum > {{(PROD_W + 1 - YEAR_W){1'b0}}, YEAR_MAX})
            begin
                y_next   = YEAR_MAX;
                ovf_next = 1'b1;
            end
            else
            begin
                y_next = sum[YEAR_W-1:0];
            end
        end

        if (cmd.emit)
        begin
            valid_next            = 1'b1;
            out_next.end_year     = y_reg;
            out_next.end_month    = m_reg;
            out_next.end_day      = d_reg;
            out_next.year_overflow = ovf_reg;
            out_next.bad_date     = bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        mode_reg <= mode_next;
        amt_reg  <= amt_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        prod_reg <= prod_next;
        ovf_reg  <= ovf_next;
        bad_reg  <= bad_next;
        out_reg  <= out_next;
    end

    assign result_valid = valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

[sv/gda_ctrl.sv]
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer: accepts an item, runs the remainder, check and step or multiply/add
// phases, and hands the finished date to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire gda_pkg::sts_t sts,
    output gda_pkg::cmd_t      cmd
);
    import gda_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REM   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DAY   = 3'd3;
    localparam logic [2:0] S_MON   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_REM;
                end
            end
            S_REM:
            begin
                cmd.rem_step = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.bad_now || (sts.mode == MODE_NONE))
                    state_next = S_DONE;
                else if ((sts.mode == MODE_DAY) || (sts.mode == MODE_WEEK))
                    state_next = S_DAY;
                else if (sts.mode == MODE_MONTH)
                    state_next = S_MON;
                else
                    state_next = S_MUL;
            end
            S_DAY:
            begin
                if (sts.cnt_zero)
                    state_next = S_DONE;
                else
                    cmd.day_step = 1'b1;
            end
            S_MON:
            begin
                if (sts.cnt_zero)
                    state_next = S_DONE;
                else
                    cmd.mon_step = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[sv/gregorian_date_adder_top.sv]
// Sequence, accept to result beat: load, remainder, check, then done for invalid
//   dates and mode 7, multiply and add in year/decade/century/millennium modes,
//   and the stepper in day, week and month modes; it moves one day or month a cycle.
// Throughput: one item at a time; the next beat is taken once the result sits
//   in the output register, even while that result waits on a stall.
// Reset: rst_n asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// gregorian_date_adder_top
// Adds days, weeks, months or years to a Gregorian date.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_adder_top
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire gda_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output gda_pkg::result_t     result
);
    import gda_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gda_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    gda_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

[sv/gda_checker.sv]
// ----------------------------------------------------------------------------
// gda_checker
// Port-level checks for the Gregorian date adder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_checker
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_stall,
    input wire gda_pkg::item_t    item,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire gda_pkg::result_t  result
);
    import gda_pkg::*;

    // a held result beat stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // one item in flight: an accepted beat blocks the input next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not stalled after accept");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.bad_date && result.year_overflow))
        else $error("bad_date and year_overflow both set");

    a_good_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.bad_date |->
            (result.end_month >= 4'd1) && (result.end_month <= 4'd12)
            && (result.end_day != 5'd0))
        else $error("valid result date out of range");

endmodule

bind gregorian_date_adder_top gda_checker u_gda_checker (.*);

`default_nettype wire
